// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, muted while arst_n is low.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same, with no reset gating.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/twr_pkg.sv =====
`default_nettype none

package twr_pkg;

	typedef enum logic [1:0] {
		FUNC_RX      = 2'd0,
		FUNC_TX      = 2'd1,
		FUNC_TIMEOUT = 2'd2,
		FUNC_IGNORE  = 2'd3
	} func_t;

	localparam logic [2:0] ACT_NONE    = 3'd0;
	localparam logic [2:0] ACT_RESET   = 3'd1;
	localparam logic [2:0] ACT_RESTART = 3'd2;
	localparam logic [2:0] ACT_ANSWER  = 3'd3;
	localparam logic [2:0] ACT_REPORT  = 3'd4;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_ANSWER = 2'd1,
		KIND_REPORT = 2'd2
	} tx_kind_t;

	localparam logic [7:0] MSG_POLL  = 8'h01;
	localparam logic [7:0] MSG_FINAL = 8'h03;
	localparam logic [7:0] LPP_CODE  = 8'd240;

	localparam logic [7:0] CFG_OWN_ADDR = 8'd0;
	localparam logic [7:0] CFG_POS_EN   = 8'd1;

	// 4000 uus at 65536 ticks each
	localparam logic [40:0] REPLY_DELAY_TICKS = 41'(4000 * 65536);

	typedef struct packed {
		logic [1:0]  func;
		logic [9:0]  frame_length;
		logic [63:0] dest_addr;
		logic [63:0] src_addr;
		logic [7:0]  msg_type;
		logic [7:0]  seq_num;
		logic [39:0] event_time;
		logic        start_failed;
	} twr_in_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [63:0] reply_dest;
		logic [7:0]  reply_seq;
		logic [31:0] tx_time;
		logic        with_position;
		logic [39:0] poll_time;
		logic [39:0] answer_time;
		logic [39:0] final_time;
	} twr_out_t;

endpackage

`default_nettype wire

// ===== src/twr_in_stage.sv =====
`default_nettype none

module twr_in_stage (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire twr_pkg::twr_in_t in_data,
	output logic                 item_valid,
	output twr_pkg::twr_in_t     item,
	input  wire logic            item_take
);
	import twr_pkg::*;

	logic     valid_s1;
	twr_in_t  data_s1;

	// Stage empties when the core takes the item, so a new one can land the same cycle.
	assign in_ready   = !valid_s1 || item_take;
	assign item_valid = valid_s1;
	assign item       = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
	end

endmodule

`default_nettype wire

// ===== src/twr_core.sv =====
`default_nettype none

module twr_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_valid,
	input  wire logic [7:0]       cfg_index,
	input  wire logic [63:0]      cfg_data,
	input  wire logic             item_valid,
	input  wire twr_pkg::twr_in_t item,
	output logic                  item_take,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output twr_pkg::twr_out_t     out_data
);
	import twr_pkg::*;
	`include "assert_macros.svh"

	logic [63:0] own_addr_q;
	logic        pos_en_q;

	logic [7:0]  tag_q,    tag_d;
	logic [39:0] poll_q,   poll_d;
	logic [39:0] answer_q, answer_d;
	logic [39:0] final_q,  final_d;
	tx_kind_t    kind_q,   kind_d;

	twr_out_t    res;
	twr_out_t    res_q;
	logic        res_valid_q;
	logic [40:0] tx_sum;

	assign item_take = item_valid && (!res_valid_q || out_ready);
	assign out_valid = res_valid_q;
	assign out_data  = res_q;
	assign tx_sum    = {1'b0, item.event_time} + REPLY_DELAY_TICKS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr_q <= '0;
			pos_en_q   <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_OWN_ADDR: own_addr_q <= cfg_data;
				CFG_POS_EN:   pos_en_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		res      = '0;
		tag_d    = tag_q;
		poll_d   = poll_q;
		answer_d = answer_q;
		final_d  = final_q;
		kind_d   = kind_q;
		unique case (func_t'(item.func))
			FUNC_RX: begin
				if (item.frame_length != '0) begin
					if (item.dest_addr != own_addr_q) begin
						res.action = ACT_RESET;
					end else if (item.msg_type == MSG_POLL) begin
						tag_d  = item.src_addr[7:0];
						kind_d = KIND_ANSWER;
						if (item.start_failed) begin
							// poll time kept only when the answer actually leaves
							res.action = ACT_RESTART;
						end else begin
							poll_d            = item.event_time;
							res.action        = ACT_ANSWER;
							res.reply_dest    = item.src_addr;
							res.reply_seq     = item.seq_num;
							res.tx_time       = tx_sum[39:8];
							res.with_position = pos_en_q;
						end
					end else if (item.msg_type == MSG_FINAL) begin
						if (tag_q != item.src_addr[7:0]) begin
							res.action = ACT_RESTART;
						end else begin
							final_d         = item.event_time;
							kind_d          = KIND_REPORT;
							res.action      = ACT_REPORT;
							res.reply_dest  = item.src_addr;
							res.reply_seq   = item.seq_num;
							res.poll_time   = poll_q;
							res.answer_time = answer_q;
							res.final_time  = item.event_time;
						end
					end else if (item.msg_type == LPP_CODE) begin
						res.action = ACT_RESTART;
					end
				end
			end
			FUNC_TX: begin
				if (kind_q == KIND_ANSWER) begin
					answer_d = item.event_time;
				end
			end
			FUNC_TIMEOUT: res.action = ACT_RESTART;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q    <= '0;
			poll_q   <= '0;
			answer_q <= '0;
			final_q  <= '0;
			kind_q   <= KIND_NONE;
		end else if (item_take) begin
			tag_q    <= tag_d;
			poll_q   <= poll_d;
			answer_q <= answer_d;
			final_q  <= final_d;
			kind_q   <= kind_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (item_take) begin
			res_valid_q <= 1'b1;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			res_q <= res;
		end
	end

	`ASSERT_CLK(a_report_sets_kind,
		item_take && res.action == ACT_REPORT |=> kind_q == KIND_REPORT,
		"report did not mark report pending")
	`ASSERT_CLK(a_answer_keeps_poll,
		item_take && res.action == ACT_ANSWER |=> poll_q == $past(item.event_time),
		"answer did not capture poll time")
	`ASSERT_CLK(a_idle_fields_zero,
		item_take && res.action != ACT_ANSWER && res.action != ACT_REPORT
		|=> res_q.reply_dest == '0 && res_q.tx_time == '0,
		"reply fields set without a reply")
	`ASSERT_CLK(a_take_needs_room,
		item_take |-> !res_valid_q || out_ready,
		"result register overwritten")

endmodule

`default_nettype wire

// ===== src/twr_ranging_anchor_responder.sv =====
// channel | signals                           | transfer when
// --------+-----------------------------------+--------------------------
// in      | in_valid in_ready in_data         | in_valid && in_ready
// out     | out_valid out_ready out_data      | out_valid && out_ready
// cfg     | cfg_valid cfg_ready cfg_index/data| cfg_valid && cfg_ready
//
// Every event yields exactly one result: input register, compare/add logic, result register.
// One event per cycle sustained unless out_ready stalls; one pass of compare/add logic.
// arst_n clears config, ranging state and both valid flags.
// A stalled output holds the input register; in_ready drops only when both are full.
// cfg_ready is tied high; writes take effect the next cycle.
`default_nettype none

module twr_ranging_anchor_responder (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire twr_pkg::twr_in_t in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output twr_pkg::twr_out_t     out_data,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [7:0]       cfg_index,
	input  wire logic [63:0]      cfg_data
);
	import twr_pkg::*;

	logic    item_valid;
	logic    item_take;
	twr_in_t item;

	assign cfg_ready = 1'b1;

	twr_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take)
	);

	twr_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

`default_nettype wire

// ===== tb/sv/twr_ranging_checker.sv =====
`timescale 1ns / 100ps

module twr_ranging_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  twr_pkg::twr_in_t  in_data,
	input  logic              out_valid,
	input  logic              out_ready,
	input  twr_pkg::twr_out_t out_data,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [7:0]        cfg_index,
	input  logic [63:0]       cfg_data,
	output int                mismatches,
	output int                pending
);
	import twr_pkg::*;

	logic [63:0] own_address;
	logic        position_on;

	logic [7:0]  tag_in_progress;
	logic [39:0] poll_rx_stamp;
	logic [39:0] answer_tx_stamp;
	logic [39:0] final_rx_stamp;
	tx_kind_t    loaded_kind;

	twr_out_t expected_replies[$];

	// Works out the reply to one radio event and advances the ranging state.
	function automatic twr_out_t anchor_response(twr_in_t ev);
		twr_out_t    r;
		logic [40:0] due;
		r = '0;
		due = {1'b0, ev.event_time} + REPLY_DELAY_TICKS;
		case (func_t'(ev.func))
			FUNC_RX: begin
				if (ev.frame_length == '0) begin
					r.action = ACT_NONE;
				end else if (ev.dest_addr != own_address) begin
					r.action = ACT_RESET;
				end else if (ev.msg_type == MSG_POLL) begin
					tag_in_progress = ev.src_addr[7:0];
					loaded_kind = KIND_ANSWER;
					if (ev.start_failed) begin
						// tag taken, but the old poll stamp stays
						r.action = ACT_RESTART;
					end else begin
						poll_rx_stamp = ev.event_time;
						r.action = ACT_ANSWER;
						r.reply_dest = ev.src_addr;
						r.reply_seq = ev.seq_num;
						r.tx_time = due[39:8];
						r.with_position = position_on;
					end
				end else if (ev.msg_type == MSG_FINAL) begin
					if (tag_in_progress != ev.src_addr[7:0]) begin
						r.action = ACT_RESTART;
					end else begin
						final_rx_stamp = ev.event_time;
						loaded_kind = KIND_REPORT;
						r.action = ACT_REPORT;
						r.reply_dest = ev.src_addr;
						r.reply_seq = ev.seq_num;
						r.poll_time = poll_rx_stamp;
						r.answer_time = answer_tx_stamp;
						r.final_time = final_rx_stamp;
					end
				end else if (ev.msg_type == LPP_CODE) begin
					r.action = ACT_RESTART;
				end
			end
			FUNC_TX: begin
				if (loaded_kind == KIND_ANSWER)
					answer_tx_stamp = ev.event_time;
			end
			FUNC_TIMEOUT: begin
				r.action = ACT_RESTART;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		twr_out_t want;
		if (!arst_n) begin
			own_address = '0;
			position_on = 1'b0;
			tag_in_progress = '0;
			poll_rx_stamp = '0;
			answer_tx_stamp = '0;
			final_rx_stamp = '0;
			loaded_kind = KIND_NONE;
			expected_replies.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_OWN_ADDR)
					own_address = cfg_data;
				else if (cfg_index == CFG_POS_EN)
					position_on = cfg_data[0];
			end
			if (in_valid && in_ready)
				expected_replies.push_back(anchor_response(in_data));
			if (out_valid && out_ready) begin
				if (expected_replies.size() == 0) begin
					$error("result transfer with nothing expected: action 0x%0h",
						out_data.action);
					mismatches++;
				end else begin
					want = expected_replies.pop_front();
					check_field("action", 64'(want.action), 64'(out_data.action));
					check_field("reply_dest", want.reply_dest, out_data.reply_dest);
					check_field("reply_seq", 64'(want.reply_seq), 64'(out_data.reply_seq));
					check_field("tx_time", 64'(want.tx_time), 64'(out_data.tx_time));
					check_field("with_position", 64'(want.with_position),
						64'(out_data.with_position));
					check_field("poll_time", 64'(want.poll_time), 64'(out_data.poll_time));
					check_field("answer_time", 64'(want.answer_time),
						64'(out_data.answer_time));
					check_field("final_time", 64'(want.final_time),
						64'(out_data.final_time));
				end
			end
			pending = expected_replies.size();
		end
	end

endmodule

// ===== tb/sv/twr_ranging_anchor_responder_tb.sv =====
`timescale 1ns / 100ps

module twr_ranging_anchor_responder_tb;
	import twr_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	twr_in_t     in_data;
	logic        out_valid;
	logic        out_ready;
	twr_out_t    out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_index;
	logic [63:0] cfg_data;
	int          mismatches;
	int          pending;

	logic [63:0] anchor_addr;
	int          events_sent;
	int          in_quiet;
	int          out_quiet;

	twr_ranging_anchor_responder u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	twr_ranging_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mismatches(mismatches),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("twr_ranging_anchor_responder regression: fail");
		$finish;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [39:0] rand40();
		return {8'($urandom), $urandom};
	endfunction

	// Idle cycles before the next transfer; now and then a stretch with none.
	function automatic int draw_wait(ref int quiet);
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0)
			quiet = $urandom_range(10, 40);
		return $urandom_range(0, 13);
	endfunction

	function automatic twr_in_t radio_event(func_t f, logic [39:0] stamp);
		twr_in_t ev;
		ev.func = f;
		ev.frame_length = 10'($urandom_range(1, 1023));
		ev.dest_addr = rand64();
		ev.src_addr = rand64();
		ev.msg_type = 8'($urandom);
		ev.seq_num = 8'($urandom);
		ev.event_time = stamp;
		ev.start_failed = 1'($urandom);
		return ev;
	endfunction

	function automatic twr_in_t rx_frame(logic [63:0] dest, logic [63:0] src, logic [7:0] kind,
		logic [7:0] seq, logic [39:0] stamp, logic failed);
		twr_in_t ev;
		ev = radio_event(FUNC_RX, stamp);
		ev.dest_addr = dest;
		ev.src_addr = src;
		ev.msg_type = kind;
		ev.seq_num = seq;
		ev.start_failed = failed;
		return ev;
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_event(twr_in_t ev);
		int gap;
		gap = draw_wait(in_quiet);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= ev;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		if (!(ev.func == FUNC_IGNORE || (ev.func == FUNC_RX && ev.frame_length == '0)))
			events_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [7:0] idx, logic [63:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic write_config(logic [63:0] addr, logic pos_en);
		wait_idle();
		write_reg(CFG_OWN_ADDR, addr);
		write_reg(CFG_POS_EN, 64'(pos_en));
		cfg_valid <= 1'b0;
		anchor_addr = addr;
	endtask

	task automatic send_noise();
		twr_in_t ev;
		int      pick;
		pick = $urandom_range(0, 15);
		ev = radio_event(FUNC_RX, rand40());
		if (pick < 10) begin
			if ($urandom_range(0, 1))
				ev.dest_addr = anchor_addr;
			case ($urandom_range(0, 3))
				0: ev.msg_type = MSG_POLL;
				1: ev.msg_type = MSG_FINAL;
				2: ev.msg_type = LPP_CODE;
				default: ev.msg_type = 8'($urandom);
			endcase
			if ($urandom_range(0, 15) == 0)
				ev.frame_length = '0;
		end else if (pick < 13) begin
			ev.func = FUNC_TX;
		end else if (pick < 15) begin
			ev.func = FUNC_TIMEOUT;
		end else begin
			ev.func = FUNC_IGNORE;
		end
		send_event(ev);
	endtask

	task automatic maybe_noise();
		if ($urandom_range(0, 3) == 0)
			send_noise();
	endtask

	// Poll, answer sent, final, report sent; random content, occasional wrong tag.
	task automatic ranging_exchange();
		logic [63:0] tag_src;
		logic [63:0] final_src;
		tag_src = rand64();
		send_event(rx_frame(anchor_addr, tag_src, MSG_POLL, 8'($urandom), rand40(),
			$urandom_range(0, 7) == 0));
		maybe_noise();
		send_event(radio_event(FUNC_TX, rand40()));
		maybe_noise();
		final_src = rand64();
		final_src[7:0] = tag_src[7:0];
		if ($urandom_range(0, 7) == 0)
			final_src[7:0] = 8'($urandom);
		send_event(rx_frame(anchor_addr, final_src, MSG_FINAL, 8'($urandom), rand40(),
			1'($urandom)));
		maybe_noise();
		send_event(radio_event(FUNC_TX, rand40()));
	endtask

	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			int stall;
			stall = draw_wait(out_quiet);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	initial begin
		twr_in_t     ev;
		logic [63:0] addr;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		anchor_addr = '0;
		events_sent = 0;
		in_quiet = 0;
		out_quiet = 0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		write_config(64'h5A3C_96E1_0F87_B2D4, 1'b1);
		// sent event while nothing is loaded: no capture
		send_event(radio_event(FUNC_TX, '1));
		ev = rx_frame(anchor_addr, '1, MSG_POLL, 8'hFF, '1, 1'b0);
		ev.frame_length = '0;
		send_event(ev);
		send_event(rx_frame(~anchor_addr, '1, MSG_POLL, 8'hFF, '1, 1'b0));
		// poll at the top of the timer range: transmit time wraps
		ev = rx_frame(anchor_addr, '1, MSG_POLL, 8'hFF, '1, 1'b0);
		ev.frame_length = '1;
		send_event(ev);
		send_event(radio_event(FUNC_TX, 40'h80_0000_0001));
		send_event(rx_frame(anchor_addr, 64'h0000_0000_0000_00FF, MSG_FINAL, 8'h00, '0, 1'b1));
		// report loaded: a sent event must not overwrite the answer stamp
		send_event(radio_event(FUNC_TX, 40'h12_3456_789A));
		send_event(rx_frame(anchor_addr, 64'hFFFF_FFFF_FFFF_FF12, MSG_FINAL, 8'h55, '1, 1'b0));
		send_event(rx_frame(anchor_addr, rand64(), LPP_CODE, 8'hA5, rand40(), 1'b0));
		send_event(rx_frame(anchor_addr, rand64(), 8'h02, 8'h5A, rand40(), 1'b0));
		send_event(rx_frame(anchor_addr, rand64(), 8'h00, 8'h01, rand40(), 1'b0));
		send_event(rx_frame(anchor_addr, rand64(), 8'hFF, 8'hFE, rand40(), 1'b1));
		// poll whose answer fails to start: tag taken, old poll stamp kept
		send_event(rx_frame(anchor_addr, 64'h0, MSG_POLL, 8'h00, 40'h0, 1'b1));
		send_event(radio_event(FUNC_TX, 40'h00_FFFF_0000));
		send_event(rx_frame(anchor_addr, 64'hAAAA_5555_AAAA_5500, MSG_FINAL, 8'h77, rand40(),
			1'b0));
		send_event(radio_event(FUNC_TIMEOUT, rand40()));
		send_event(radio_event(FUNC_IGNORE, rand40()));
		send_event(rx_frame(anchor_addr, 64'h0, MSG_POLL, 8'h00, 40'h0, 1'b0));
		send_event(radio_event(FUNC_TX, rand40()));
		send_event(rx_frame(anchor_addr, 64'h0, MSG_FINAL, 8'h01, rand40(), 1'b0));

		for (int phase = 0; phase < 6; phase++) begin
			if (phase == 0)
				addr = '0;
			else if (phase == 1)
				addr = '1;
			else
				addr = rand64();
			write_config(addr, phase[0]);
			events_sent = 0;
			while (events_sent < 175) begin
				if ($urandom_range(0, 4) != 0)
					ranging_exchange();
				else
					repeat (3) send_noise();
			end
		end

		wait_idle();
		repeat (16) @(negedge clk);
		if (mismatches == 0 && pending == 0)
			$display("twr_ranging_anchor_responder regression: pass");
		else
			$display("twr_ranging_anchor_responder regression: fail");
		$finish;
	end

endmodule

// ===== twr_ranging_anchor_responder.f =====
+incdir+src
src/twr_pkg.sv
src/twr_in_stage.sv
src/twr_core.sv
src/twr_ranging_anchor_responder.sv
tb/sv/twr_ranging_checker.sv
tb/sv/twr_ranging_anchor_responder_tb.sv
